// ===== src/page_bitmap_allocator_assert.svh =====
// Assertion macros for the page bitmap allocator.
`ifndef PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define PBA_ASSERT_IMPLY(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("pba: same-cycle check failed");

// Next-cycle implication.
`define PBA_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("pba: next-cycle check failed");

// Invariant.
`define PBA_ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pba: invariant failed");

`endif

// ===== src/pba_pkg.sv =====
`default_nettype none

package pba_pkg;

   localparam int unsigned MAX_PAGES_DEF  = 32768;
   localparam int unsigned PAGE_BYTES_DEF = 4096;
   localparam int unsigned WORD_BITS_DEF  = 32;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVED = 2'd2;

   localparam logic [15:0] COUNT_RESET = 16'd32768;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_INIT  = 2'd2;

   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_EMPTY   = 3'd1;
   localparam logic [2:0] STAT_LOW     = 3'd2;
   localparam logic [2:0] STAT_HIGH    = 3'd3;
   localparam logic [2:0] STAT_UNALLOC = 3'd4;

   typedef struct packed {
      logic latch_req;
      logic alloc_start;
      logic alloc_empty;
      logic free_start;
      logic mem_rd;
      logic scan_end;
      logic scan_hit;
      logic scan_next;
      logic alloc_wr;
      logic free_wr;
      logic sweep_start;
      logic sweep_step;
      logic load_rsp;
   } pba_cmd_type;

   typedef struct packed {
      logic [1:0] cmd_code;
      logic       alloc_empty;
      logic       free_bad;
      logic       scan_out;
      logic       scan_hit;
      logic       scan_second;
      logic       sweep_last;
   } pba_stat_type;

endpackage

`default_nettype wire

// ===== src/page_bitmap_allocator.sv =====
// Channel  Handshake              Payload
// req      req_valid/req_ready    req_command, req_page_address
// rsp      rsp_valid/rsp_ready    rsp_result_address, rsp_status
// csr      csr_valid/csr_ready    csr_index, csr_data (csr_ready always high)
//
// Reset clears all NWORDS bitmap words (1024 at default sizes); no request is taken.
// Free reads the bitmap word, then checks and clears the bit; out of range, it skips both.
// Unknown commands answer directly; init sweeps all words. Allocate reads words from the hint
// until a free bit turns up, sets it, scans on to refresh the hint; a full hint skips the scan.
// A new request is taken while the previous result still waits in the output register;
// a stalled result holds the block in its response state until the transfer.
`default_nettype none

module page_bitmap_allocator #(
   parameter int unsigned MAX_PAGES  = pba_pkg::MAX_PAGES_DEF,
   parameter int unsigned PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF,
   parameter int unsigned WORD_BITS  = pba_pkg::WORD_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_command,
   input  wire logic [31:0]                      req_page_address,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [31:0]                           rsp_result_address,
   output logic [2:0]                            rsp_status,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [pba_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [pba_pkg::CSR_DATA_W-1:0]   csr_data
);

   pba_pkg::pba_cmd_type  cmd;
   pba_pkg::pba_stat_type stat;

   assign csr_ready = 1'b1;

   pba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pba_datapath #(
      .MAX_PAGES  (MAX_PAGES),
      .PAGE_BYTES (PAGE_BYTES),
      .WORD_BITS  (WORD_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_command        (req_command),
      .req_page_address   (req_page_address),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status)
   );

endmodule

`default_nettype wire

// ===== src/pba_datapath.sv =====
`default_nettype none
`include "page_bitmap_allocator_assert.svh"

module pba_datapath #(
   parameter int unsigned MAX_PAGES  = pba_pkg::MAX_PAGES_DEF,
   parameter int unsigned PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF,
   parameter int unsigned WORD_BITS  = pba_pkg::WORD_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [1:0]                       req_command,
   input  wire logic [31:0]                      req_page_address,
   input  wire logic                             csr_valid,
   input  wire logic [pba_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [pba_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire pba_pkg::pba_cmd_type             cmd,
   output pba_pkg::pba_stat_type                 stat,
   output logic [31:0]                           rsp_result_address,
   output logic [2:0]                            rsp_status
);

   localparam int unsigned WBL    = $clog2(WORD_BITS);
   localparam int unsigned PBL    = $clog2(PAGE_BYTES);
   localparam int unsigned NWORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned WW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int unsigned WCW    = $clog2(NWORDS + 1);
   localparam int unsigned CW     = $clog2(MAX_PAGES + 1);
   localparam int unsigned LIM_W  = (((CW + PBL) > 32) ? (CW + PBL) : 32) + 1;

   logic [31:0]          base_ff, base_in;
   logic [15:0]          count_ff, count_in;
   logic [14:0]          reserved_ff, reserved_in;
   logic [1:0]           cmd_ff, cmd_in;
   logic [31:0]          addr_ff, addr_in;
   logic [CW-1:0]        hint_ff, hint_in;
   logic [WCW-1:0]       w_ff, w_in;
   logic [CW-1:0]        from_ff, from_in;
   logic                 second_ff, second_in;
   logic                 mark_ff, mark_in;
   logic [WBL-1:0]       pick_ff, pick_in;
   logic [31:0]          stage_addr_ff, stage_addr_in;
   logic [2:0]           stage_status_ff, stage_status_in;
   logic [31:0]          rsp_addr_ff, rsp_addr_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;

   logic [WORD_BITS-1:0] mem [NWORDS];
   logic [WORD_BITS-1:0] rdata_ff;

   logic [CW-1:0]        n_cnt;
   logic [31:0]          wpage32;
   logic [31:0]          from_w32;
   logic [WBL-1:0]       from_b;
   logic [31:0]          n_w32;
   logic [WBL-1:0]       n_b;
   logic [WORD_BITS-1:0] cand;
   logic [WBL-1:0]       ffs;
   logic [31:0]          hit_page32;
   logic [31:0]          page_sel32;
   logic [CW-1:0]        page_sel;
   logic [WORD_BITS-1:0] sel_bit;
   logic                 bit_used;
   logic [31:0]          off32;
   logic [31:0]          fpage32;
   logic [LIM_W-1:0]     lim;
   logic                 too_low;
   logic                 too_high;
   logic [31:0]          top32;
   logic [31:0]          top_w32;
   logic [WBL-1:0]       top_b;
   logic [WORD_BITS-1:0] sweep_mask;
   logic                 sweep_last;
   logic [WW-1:0]        widx;

   assign n_cnt      = (32'(count_ff) > 32'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(count_ff);
   assign wpage32    = 32'(w_ff) << WBL;
   assign from_w32   = 32'(from_ff) >> WBL;
   assign from_b     = WBL'(from_ff);
   assign n_w32      = 32'(n_cnt) >> WBL;
   assign n_b        = WBL'(n_cnt);
   assign widx       = w_ff[WW-1:0];

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         cand[b] = !rdata_ff[b]
                   && ((32'(w_ff) != from_w32) || (WBL'(b) >= from_b))
                   && ((32'(w_ff) != n_w32) || (WBL'(b) < n_b));
      end
   end

   always_comb begin
      ffs = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (cand[b]) begin
            ffs = WBL'(b);
         end
      end
   end

   assign hit_page32 = wpage32 | 32'(ffs);
   assign page_sel32 = wpage32 | 32'(pick_ff);
   assign page_sel   = CW'(page_sel32);
   assign sel_bit    = WORD_BITS'(1) << pick_ff;
   assign bit_used   = rdata_ff[pick_ff];

   assign off32    = addr_ff - base_ff;
   assign fpage32  = off32 >> PBL;
   assign lim      = LIM_W'(base_ff) + (LIM_W'(n_cnt) << PBL);
   assign too_low  = addr_ff < base_ff;
   assign too_high = LIM_W'(addr_ff) >= lim;

   assign top32   = (32'(reserved_ff) >= 32'(MAX_PAGES)) ? 32'(MAX_PAGES - 1)
                                                          : 32'(reserved_ff);
   assign top_w32 = top32 >> WBL;
   assign top_b   = WBL'(top32);

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         sweep_mask[b] = mark_ff && ((32'(w_ff) < top_w32)
                         || ((32'(w_ff) == top_w32) && (WBL'(b) <= top_b)));
      end
   end

   assign sweep_last = 32'(w_ff) == 32'(NWORDS - 1);

   always_comb begin
      stat.cmd_code    = cmd_ff;
      stat.alloc_empty = hint_ff >= n_cnt;
      stat.free_bad    = too_low || too_high;
      stat.scan_out    = (32'(w_ff) >= 32'(NWORDS)) || (wpage32 >= 32'(n_cnt));
      stat.scan_hit    = |cand;
      stat.scan_second = second_ff;
      stat.sweep_last  = sweep_last;
   end

   always_comb begin
      base_in         = base_ff;
      count_in        = count_ff;
      reserved_in     = reserved_ff;
      cmd_in          = cmd_ff;
      addr_in         = addr_ff;
      hint_in         = hint_ff;
      w_in            = w_ff;
      from_in         = from_ff;
      second_in       = second_ff;
      mark_in         = mark_ff;
      pick_in         = pick_ff;
      stage_addr_in   = stage_addr_ff;
      stage_status_in = stage_status_ff;
      rsp_addr_in     = rsp_addr_ff;
      rsp_status_in   = rsp_status_ff;

      if (csr_valid) begin
         unique case (csr_index)
            pba_pkg::CSR_BASE:     base_in     = csr_data[31:0];
            pba_pkg::CSR_COUNT:    count_in    = csr_data[15:0];
            pba_pkg::CSR_RESERVED: reserved_in = csr_data[14:0];
            default: ;
         endcase
      end

      if (cmd.latch_req) begin
         cmd_in          = req_command;
         addr_in         = req_page_address;
         stage_addr_in   = '0;
         stage_status_in = pba_pkg::STAT_OK;
      end

      if (cmd.alloc_empty) begin
         hint_in         = n_cnt;
         stage_status_in = pba_pkg::STAT_EMPTY;
      end

      if (cmd.alloc_start) begin
         from_in   = hint_ff;
         w_in      = WCW'(32'(hint_ff) >> WBL);
         second_in = 1'b0;
      end

      if (cmd.free_start) begin
         w_in    = WCW'(fpage32 >> WBL);
         pick_in = WBL'(fpage32);
         if (too_low) begin
            stage_status_in = pba_pkg::STAT_LOW;
         end else if (too_high) begin
            stage_status_in = pba_pkg::STAT_HIGH;
         end
      end

      if (cmd.scan_end) begin
         hint_in = n_cnt;
         if (!second_ff) begin
            stage_status_in = pba_pkg::STAT_EMPTY;
         end
      end

      if (cmd.scan_next) begin
         w_in = w_ff + WCW'(1);
      end

      if (cmd.scan_hit) begin
         pick_in = ffs;
         if (second_ff) begin
            hint_in = CW'(hit_page32);
         end
      end

      if (cmd.alloc_wr) begin
         stage_addr_in = base_ff + (page_sel32 << PBL);
         from_in       = CW'(wpage32);
         second_in     = 1'b1;
      end

      if (cmd.free_wr) begin
         if (bit_used) begin
            if (page_sel < hint_ff) begin
               hint_in = page_sel;
            end
         end else begin
            stage_status_in = pba_pkg::STAT_UNALLOC;
         end
      end

      if (cmd.sweep_start) begin
         w_in    = '0;
         mark_in = 1'b1;
      end

      if (cmd.sweep_step) begin
         w_in = w_ff + WCW'(1);
         if (sweep_last && mark_ff) begin
            hint_in = CW'(top32 + 32'd1);
         end
      end

      if (cmd.load_rsp) begin
         rsp_addr_in   = stage_addr_ff;
         rsp_status_in = stage_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= '0;
         count_ff    <= pba_pkg::COUNT_RESET;
         reserved_ff <= '0;
         hint_ff     <= '0;
         w_ff        <= '0;
         mark_ff     <= 1'b0;
      end else begin
         base_ff     <= base_in;
         count_ff    <= count_in;
         reserved_ff <= reserved_in;
         hint_ff     <= hint_in;
         w_ff        <= w_in;
         mark_ff     <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      addr_ff         <= addr_in;
      from_ff         <= from_in;
      second_ff       <= second_in;
      pick_ff         <= pick_in;
      stage_addr_ff   <= stage_addr_in;
      stage_status_ff <= stage_status_in;
      rsp_addr_ff     <= rsp_addr_in;
      rsp_status_ff   <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rdata_ff <= mem[widx];
      end
      if (cmd.sweep_step) begin
         mem[widx] <= sweep_mask;
      end else if (cmd.alloc_wr) begin
         mem[widx] <= rdata_ff | sel_bit;
      end else if (cmd.free_wr && bit_used) begin
         mem[widx] <= rdata_ff & ~sel_bit;
      end
   end

   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;

   `PBA_ASSERT_IMPLY(a_alloc_bit_free, clock, reset, cmd.alloc_wr, !rdata_ff[pick_ff])
   `PBA_ASSERT_IMPLY(a_hit_in_range, clock, reset, cmd.scan_hit, hit_page32 < 32'(n_cnt))
   `PBA_ASSERT_ALWAYS(a_hint_bound, clock, reset, 32'(hint_ff) <= 32'(MAX_PAGES))

endmodule

`default_nettype wire

// ===== src/pba_ctrl.sv =====
`default_nettype none
`include "page_bitmap_allocator_assert.svh"

module pba_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire pba_pkg::pba_stat_type stat,
   output pba_pkg::pba_cmd_type       cmd
);

   typedef enum logic [9:0] {
      S_CLEAR    = 10'b00_0000_0001,
      S_IDLE     = 10'b00_0000_0010,
      S_DISPATCH = 10'b00_0000_0100,
      S_SCAN_RD  = 10'b00_0000_1000,
      S_SCAN_CHK = 10'b00_0001_0000,
      S_ALLOC_WR = 10'b00_0010_0000,
      S_FREE_RD  = 10'b00_0100_0000,
      S_FREE_CHK = 10'b00_1000_0000,
      S_INIT     = 10'b01_0000_0000,
      S_RESP     = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_CLEAR: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (stat.cmd_code == pba_pkg::CMD_ALLOC) begin
               if (stat.alloc_empty) begin
                  cmd.alloc_empty = 1'b1;
                  state_in        = S_RESP;
               end else begin
                  cmd.alloc_start = 1'b1;
                  state_in        = S_SCAN_RD;
               end
            end else if (stat.cmd_code == pba_pkg::CMD_FREE) begin
               cmd.free_start = 1'b1;
               state_in       = stat.free_bad ? S_RESP : S_FREE_RD;
            end else if (stat.cmd_code == pba_pkg::CMD_INIT) begin
               cmd.sweep_start = 1'b1;
               state_in        = S_INIT;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SCAN_RD: begin
            if (stat.scan_out) begin
               cmd.scan_end = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (stat.scan_hit) begin
               cmd.scan_hit = 1'b1;
               state_in     = stat.scan_second ? S_RESP : S_ALLOC_WR;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_ALLOC_WR: begin
            cmd.alloc_wr = 1'b1;
            state_in     = S_SCAN_RD;
         end
         S_FREE_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_FREE_CHK;
         end
         S_FREE_CHK: begin
            cmd.free_wr = 1'b1;
            state_in    = S_RESP;
         end
         S_INIT: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   `PBA_ASSERT_NEXT(a_accept_dispatch, clock, reset, req_valid && req_ready, state_ff == S_DISPATCH)
   `PBA_ASSERT_NEXT(a_resp_load, clock, reset, (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && (state_ff == S_IDLE))

endmodule

`default_nettype wire
